>>> rtl/mbrx_pkg.sv
// Package: shared types and constants for the Modbus RTU request receiver
`timescale 1ns / 1ps
package mbrx_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CRC     = 3'd1;
  localparam logic [2:0] ST_ADDR    = 3'd2;
  localparam logic [2:0] ST_FUNC    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_OVERRUN = 3'd5;

  localparam logic [1:0] REG_GAP     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_NODE    = 2'd2;

  localparam logic [7:0]  FUNC_READ_REGS = 8'd3;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [16:0] TICK_LIMIT     = 17'h1FFFF;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_ADDR    = 6'b000010,
    PH_FUNC    = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC     = 6'b010000,
    PH_TRAIL   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        broadcast;
    logic [15:0] start_register;
    logic [15:0] register_count;
    logic [4:0]  trailing_bytes;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/mbrx_front.sv
// Front: frame parser that classifies bytes and ticks into results
`timescale 1ns / 1ps
module mbrx_front #(
  parameter int TRAILING_MAX = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                kind,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         gap_ticks,
  input  logic [15:0]         timeout_ticks,
  input  logic [7:0]          node_addr,
  output logic                res_valid,
  output mbrx_pkg::result_t   res
);
  import mbrx_pkg::*;

  localparam logic [7:0] TRAIL_MAX = TRAILING_MAX[7:0];

  phase_t      phase, phase_next;
  logic [16:0] tick_counter, tick_counter_next;
  logic [15:0] crc_register, crc_register_next;
  logic [7:0]  frame_address, frame_address_next;
  logic [31:0] payload_bytes, payload_bytes_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [7:0]  trailing_count, trailing_count_next;
  logic        payload_done, payload_done_next;
  logic        emit;
  logic [2:0]  emit_status;
  logic [16:0] tick_inc;
  logic [15:0] crc_fed;
  logic        show;

  assign tick_inc = (tick_counter < TICK_LIMIT) ? tick_counter + 17'd1 : tick_counter;
  assign crc_fed  = crc_feed(crc_register, rx_byte);

  always_comb begin
    phase_next          = phase;
    tick_counter_next   = tick_counter;
    crc_register_next   = crc_register;
    frame_address_next  = frame_address;
    payload_bytes_next  = payload_bytes;
    byte_index_next     = byte_index;
    crc_low_byte_next   = crc_low_byte;
    trailing_count_next = trailing_count;
    payload_done_next   = payload_done;
    emit                = 1'b0;
    emit_status         = ST_OK;
    case (phase)
      PH_HUNT: begin
        if (kind) begin
          tick_counter_next = tick_inc;
          if (tick_inc > {1'b0, gap_ticks}) begin
            phase_next        = PH_ADDR;
            tick_counter_next = '0;
          end
        end else begin
          tick_counter_next = '0;
        end
      end
      PH_ADDR: begin
        if (!kind) begin
          frame_address_next  = rx_byte;
          crc_register_next   = crc_feed(CRC_INIT, rx_byte);
          payload_bytes_next  = '0;
          payload_done_next   = 1'b0;
          byte_index_next     = '0;
          trailing_count_next = '0;
          tick_counter_next   = '0;
          phase_next          = PH_FUNC;
        end
      end
      PH_FUNC, PH_PAYLOAD, PH_CRC: begin
        if (kind) begin
          tick_counter_next = tick_inc;
          if (tick_inc > {1'b0, timeout_ticks}) begin
            emit        = 1'b1;
            emit_status = ST_TIMEOUT;
          end
        end else begin
          tick_counter_next = '0;
          if (phase == PH_FUNC) begin
            crc_register_next = crc_fed;
            if (rx_byte != FUNC_READ_REGS) begin
              emit        = 1'b1;
              emit_status = ST_FUNC;
            end else begin
              byte_index_next = '0;
              phase_next      = PH_PAYLOAD;
            end
          end else if (phase == PH_PAYLOAD) begin
            crc_register_next  = crc_fed;
            payload_bytes_next = {payload_bytes[23:0], rx_byte};
            byte_index_next    = byte_index + 2'd1;
            if (byte_index == 2'd3) begin
              payload_done_next = 1'b1;
              phase_next        = PH_CRC;
            end
          end else if (byte_index == 2'd0) begin
            crc_low_byte_next = rx_byte;
            byte_index_next   = 2'd1;
          end else begin
            byte_index_next = '0;
            if ({rx_byte, crc_low_byte} != crc_register) begin
              emit        = 1'b1;
              emit_status = ST_CRC;
            end else if (frame_address != 8'd0 && frame_address != node_addr) begin
              emit        = 1'b1;
              emit_status = ST_ADDR;
            end else begin
              trailing_count_next = '0;
              phase_next          = PH_TRAIL;
            end
          end
        end
      end
      PH_TRAIL: begin
        if (kind) begin
          tick_counter_next = tick_inc;
          if (tick_inc > {1'b0, gap_ticks}) begin
            emit        = 1'b1;
            emit_status = ST_OK;
          end
        end else begin
          tick_counter_next = '0;
          if (trailing_count >= TRAIL_MAX) begin
            emit        = 1'b1;
            emit_status = ST_OVERRUN;
          end else begin
            trailing_count_next = trailing_count + 8'd1;
          end
        end
      end
      default: begin
        phase_next        = PH_HUNT;
        tick_counter_next = '0;
      end
    endcase
    if (emit) begin
      phase_next        = PH_HUNT;
      tick_counter_next = '0;
    end
  end

  assign show = payload_done_next && emit_status != ST_FUNC;

  always_comb begin
    res.status         = emit_status;
    res.broadcast      = (frame_address_next == 8'd0);
    res.start_register = show ? payload_bytes_next[31:16] : 16'd0;
    res.register_count = show ? payload_bytes_next[15:0] : 16'd0;
    res.trailing_bytes = (emit_status == ST_OK || emit_status == ST_OVERRUN)
                         ? trailing_count_next[4:0] : 5'd0;
  end
  assign res_valid = in_fire && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      tick_counter   <= '0;
      crc_register   <= CRC_INIT;
      frame_address  <= '0;
      payload_bytes  <= '0;
      byte_index     <= '0;
      crc_low_byte   <= '0;
      trailing_count <= '0;
      payload_done   <= 1'b0;
    end else if (in_fire) begin
      phase          <= phase_next;
      tick_counter   <= tick_counter_next;
      crc_register   <= crc_register_next;
      frame_address  <= frame_address_next;
      payload_bytes  <= payload_bytes_next;
      byte_index     <= byte_index_next;
      crc_low_byte   <= crc_low_byte_next;
      trailing_count <= trailing_count_next;
      payload_done   <= payload_done_next;
    end
  end

endmodule

>>> rtl/mbrx_queue.sv
// Queue: two-entry result buffer between parser and output channel
`timescale 1ns / 1ps
module mbrx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mbrx_pkg::result_t wr_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mbrx_pkg::result_t out_data
);
  import mbrx_pkg::*;

  result_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rd_en     = out_valid && !out_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

>>> rtl/modbus_rtu_request_receiver_core.sv
// Top level: Modbus RTU request receiver with config registers and result queue
//
//  channel  | handshake              | beat
//  ---------+------------------------+----------------------------------------------
//  in       | in_valid / in_stall    | kind, rx_byte
//  out      | out_valid / out_stall  | status, broadcast, start_register, ...
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// One input beat per cycle unless stalled; the parser updates in that cycle.
// A result is written to the two-entry queue at the edge that accepts its beat
// and is offered on out behind any earlier result still queued.
// in_stall rises only when the queue is full; out_stall holds results there.
// Reset is synchronous and returns the parser to hunting for silence.
`timescale 1ns / 1ps
module modbus_rtu_request_receiver_core #(
  parameter int TRAILING_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        broadcast,
  output logic [15:0] start_register,
  output logic [15:0] register_count,
  output logic [4:0]  trailing_bytes,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mbrx_pkg::*;

  logic [15:0] frame_gap_ticks;
  logic [15:0] byte_timeout_ticks;
  logic [7:0]  node_address;
  logic        in_fire;
  logic        res_valid, full;
  result_t     res, q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap_ticks    <= 16'd1750;
      byte_timeout_ticks <= 16'd750;
      node_address       <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAP:     frame_gap_ticks    <= cfg_data;
        REG_TIMEOUT: byte_timeout_ticks <= cfg_data;
        REG_NODE:    node_address       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign in_fire  = in_valid && !in_stall;

  mbrx_front #(.TRAILING_MAX(TRAILING_MAX)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .kind          (kind),
    .rx_byte       (rx_byte),
    .gap_ticks     (frame_gap_ticks),
    .timeout_ticks (byte_timeout_ticks),
    .node_addr     (node_address),
    .res_valid     (res_valid),
    .res           (res)
  );

  mbrx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (res_valid),
    .wr_data   (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign status         = q_data.status;
  assign broadcast      = q_data.broadcast;
  assign start_register = q_data.start_register;
  assign register_count = q_data.register_count;
  assign trailing_bytes = q_data.trailing_bytes;

endmodule

>>> bench/modbus_rtu_request_receiver_core_tb.sv
// Testbench: Modbus RTU request receiver core checked against a beat-level predictor
`timescale 1ns / 1ps
module modbus_rtu_request_receiver_core_tb;
  import mbrx_pkg::*;

  localparam int TRAIL_LIMIT = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        broadcast;
  logic [15:0] start_register;
  logic [15:0] register_count;
  logic [4:0]  trailing_bytes;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GAP;
  logic [15:0] cfg_data = 16'd0;

  modbus_rtu_request_receiver_core dut (.*);

  always #5 clk = ~clk;

  // predictor state and register copies
  phase_t      ph;
  logic [16:0] tick_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  frame_addr;
  logic [31:0] payload;
  logic [2:0]  pay_idx;
  logic [7:0]  crc_lo;
  logic [4:0]  trail_cnt;
  bit          payload_full;
  logic [15:0] gap_reg;
  logic [15:0] timeout_reg;
  logic [7:0]  node_reg;

  result_t     expected_frames[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          stall_left = 0;
  int          results_seen = 0;
  int          results_drawn = 0;
  bit          no_idle = 0;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ 16'hA001;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic close_frame(input logic [2:0] s);
    result_t r;
    bit show;
    show = payload_full && (s != ST_FUNC);
    r.status = s;
    r.broadcast = (frame_addr == 8'd0);
    r.start_register = show ? payload[31:16] : 16'd0;
    r.register_count = show ? payload[15:0] : 16'd0;
    r.trailing_bytes = (s == ST_OK || s == ST_OVERRUN) ? trail_cnt : 5'd0;
    expected_frames.push_back(r);
    ph = PH_HUNT;
    tick_cnt = '0;
  endtask

  task automatic count_tick();
    if (tick_cnt != 17'h1FFFF) tick_cnt = tick_cnt + 1'b1;
  endtask

  task automatic predict_beat(input logic is_tick, input logic [7:0] b);
    logic [15:0] got;
    case (ph)
      PH_HUNT: begin
        if (is_tick) begin
          count_tick();
          if (tick_cnt > {1'b0, gap_reg}) begin
            ph = PH_ADDR;
            tick_cnt = '0;
          end
        end else begin
          tick_cnt = '0;
        end
      end
      PH_ADDR: begin
        if (!is_tick) begin
          frame_addr = b;
          crc_acc = crc_next(16'hFFFF, b);
          payload = '0;
          payload_full = 0;
          pay_idx = '0;
          trail_cnt = '0;
          tick_cnt = '0;
          ph = PH_FUNC;
        end
      end
      PH_FUNC, PH_PAYLOAD, PH_CRC: begin
        if (is_tick) begin
          count_tick();
          if (tick_cnt > {1'b0, timeout_reg}) close_frame(ST_TIMEOUT);
        end else begin
          tick_cnt = '0;
          if (ph == PH_FUNC) begin
            crc_acc = crc_next(crc_acc, b);
            if (b != FUNC_READ_REGS) begin
              close_frame(ST_FUNC);
            end else begin
              pay_idx = '0;
              ph = PH_PAYLOAD;
            end
          end else if (ph == PH_PAYLOAD) begin
            crc_acc = crc_next(crc_acc, b);
            payload = {payload[23:0], b};
            pay_idx = pay_idx + 1'b1;
            if (pay_idx >= 3'd4) begin
              payload_full = 1;
              pay_idx = '0;
              ph = PH_CRC;
            end
          end else if (pay_idx == 3'd0) begin
            crc_lo = b;
            pay_idx = 3'd1;
          end else begin
            got = {b, crc_lo};
            pay_idx = '0;
            if (got != crc_acc) close_frame(ST_CRC);
            else if (frame_addr != 8'd0 && frame_addr != node_reg) close_frame(ST_ADDR);
            else begin
              trail_cnt = '0;
              ph = PH_TRAIL;
            end
          end
        end
      end
      PH_TRAIL: begin
        if (is_tick) begin
          count_tick();
          if (tick_cnt > {1'b0, gap_reg}) close_frame(ST_OK);
        end else begin
          tick_cnt = '0;
          if (trail_cnt >= TRAIL_LIMIT) close_frame(ST_OVERRUN);
          else trail_cnt = trail_cnt + 1'b1;
        end
      end
      default: begin
        ph = PH_HUNT;
        tick_cnt = '0;
      end
    endcase
  endtask

  task automatic send_beat(input logic k, input logic [7:0] b);
    int idle;
    idle = no_idle ? 0 : $urandom_range(0, 8);
    repeat (idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_beat(k, b);
    beats_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(1'b1, 8'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GAP) gap_reg = val;
    else if (idx == REG_TIMEOUT) timeout_reg = val;
    else if (idx == REG_NODE) node_reg = val[7:0];
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] g, input logic [15:0] t, input logic [7:0] n);
    wait_results_done();
    write_reg(REG_GAP, g);
    write_reg(REG_TIMEOUT, t);
    write_reg(REG_NODE, {8'h00, n});
  endtask

  // late_at: position of the byte before which the line goes quiet too long
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fn,
                            input logic [15:0] st, input logic [15:0] cnt,
                            input bit bad_crc, input int trail, input int late_at);
    logic [7:0]  fb[8];
    logic [15:0] c;
    int          n;
    int          tmax;
    int          gmax;
    send_ticks(int'(gap_reg) + 1);
    send_ticks($urandom_range(0, 2));
    fb[0] = addr;
    fb[1] = fn;
    fb[2] = st[15:8];
    fb[3] = st[7:0];
    fb[4] = cnt[15:8];
    fb[5] = cnt[7:0];
    c = 16'hFFFF;
    for (int i = 0; i < 6; i++) c = crc_next(c, fb[i]);
    fb[6] = c[7:0] ^ (bad_crc ? 8'h01 : 8'h00);
    fb[7] = c[15:8];
    n = (fn != FUNC_READ_REGS) ? 2 : 8;
    tmax = (timeout_reg < 3) ? int'(timeout_reg) : 3;
    gmax = (gap_reg < 3) ? int'(gap_reg) : 3;
    for (int i = 0; i < n; i++) begin
      if (i == late_at) begin
        send_ticks(int'(timeout_reg) + 1);
        return;
      end
      if (i > 0) send_ticks($urandom_range(0, tmax));
      send_beat(1'b0, fb[i]);
    end
    if (n < 8) return;
    for (int j = 0; j < trail; j++) begin
      send_ticks($urandom_range(0, gmax));
      send_beat(1'b0, 8'($urandom));
    end
    send_ticks(int'(gap_reg) + 1);
  endtask

  task automatic test_reset_values();
    send_frame(8'd1, FUNC_READ_REGS, 16'h1234, 16'h0010, 0, 1, -1);
    send_frame(8'd1, FUNC_READ_REGS, 16'h0001, 16'h0002, 0, 0, 3);
  endtask

  task automatic test_directed();
    configure(16'd4, 16'd3, 8'd247);
    send_frame(8'd247, FUNC_READ_REGS, 16'hFFFF, 16'h0000, 0, 0, -1);
    send_frame(8'd0, FUNC_READ_REGS, 16'h0000, 16'hFFFF, 0, 2, -1);
    send_frame(8'd247, FUNC_READ_REGS, 16'h00FF, 16'hFF00, 1, 0, -1);
    send_frame(8'd5, FUNC_READ_REGS, 16'h5555, 16'hAAAA, 0, 0, -1);
    send_frame(8'd247, 8'd0, 16'd0, 16'd0, 0, 0, -1);
    send_frame(8'd255, 8'd255, 16'd0, 16'd0, 0, 0, -1);
    send_frame(8'd247, FUNC_READ_REGS, 16'd1, 16'd1, 0, 0, 1);
    send_frame(8'd0, FUNC_READ_REGS, 16'hBEEF, 16'hCAFE, 0, 0, 6);
    send_frame(8'd247, FUNC_READ_REGS, 16'h0102, 16'h0304, 0, 17, -1);
    send_frame(8'd247, FUNC_READ_REGS, 16'h0A0B, 16'h0C0D, 0, 16, -1);
    configure(16'd1, 16'd1, 8'd0);
    send_frame(8'd0, FUNC_READ_REGS, 16'h7FFF, 16'h8000, 0, 1, -1);
    send_frame(8'd9, FUNC_READ_REGS, 16'h0001, 16'h0001, 0, 0, 4);
  endtask

  task automatic test_long_gaps();
    configure(16'd65535, 16'd65535, 8'd247);
    no_idle = 1;
    send_frame(8'd247, FUNC_READ_REGS, 16'h4000, 16'h007D, 0, 1, -1);
    no_idle = 0;
  endtask

  task automatic test_random(input int target);
    int       phase_end;
    int       sel;
    logic [7:0] a;
    logic [7:0] f;
    int       tr;
    int       late;
    while (beats_sent < target) begin
      configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                8'($urandom_range(1, 247)));
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = beats_sent + 200;
      while (beats_sent < phase_end && beats_sent < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          repeat ($urandom_range(1, 6)) send_beat(1'($urandom), 8'($urandom));
        end else begin
          sel = $urandom_range(0, 9);
          a = (sel < 5) ? node_reg : (sel < 7) ? 8'd0 : 8'($urandom);
          f = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_READ_REGS;
          tr = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
          late = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 7) : -1;
          send_frame(a, f, 16'($urandom), 16'($urandom), $urandom_range(0, 9) == 0, tr, late);
        end
        if (beats_sent > phase_end - 60 && expected_frames.size() != 0 &&
            $urandom_range(0, 20) == 0) wait_results_done();
      end
    end
  endtask

  always @(negedge clk) begin
    int draw;
    if (results_seen != results_drawn) begin
      results_drawn <= results_seen;
      draw = $urandom_range(0, 8);
      if (draw > 0) begin
        out_stall <= 1'b1;
        stall_left <= draw - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status);
      end else begin
        want = expected_frames.pop_front();
        if (status !== want.status || broadcast !== want.broadcast ||
            start_register !== want.start_register ||
            register_count !== want.register_count ||
            trailing_bytes !== want.trailing_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp %0d %0d %h %h %0d got %0d %0d %h %h %0d",
                     want.status, want.broadcast, want.start_register,
                     want.register_count, want.trailing_bytes, status, broadcast,
                     start_register, register_count, trailing_bytes);
        end
      end
    end
  end

  initial begin
    ph = PH_HUNT;
    tick_cnt = '0;
    crc_acc = 16'hFFFF;
    frame_addr = '0;
    payload = '0;
    pay_idx = '0;
    crc_lo = '0;
    trail_cnt = '0;
    payload_full = 0;
    gap_reg = 16'd1750;
    timeout_reg = 16'd750;
    node_reg = 8'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_long_gaps();
    test_random(1050 + beats_sent);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_done();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
